// File: rtl/fibonacci_mod_prime_matrix_power_defines.svh
// Assertion macros used by the top-level RTL file of the Fibonacci matrix power block.
`ifndef FIBONACCI_MOD_PRIME_MATRIX_POWER_DEFINES_SVH
`define FIBONACCI_MOD_PRIME_MATRIX_POWER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FMP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fmp assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define FMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fmp assertion failed");

`endif

// File: rtl/fmp_pkg.sv
// Package with the modulus, reduction constants and a residue addition helper.
`default_nettype none
package fmp_pkg;

   localparam int DEFAULT_INDEX_WIDTH = 64;
   localparam int RES_W = 30;

   typedef logic [RES_W-1:0] residue_type;

   localparam residue_type PRIME = 30'd1000000007;
   localparam logic [31:0] PRIME_TWICE = 32'd2000000014;

   // Barrett factor: floor(2^60 / PRIME), which needs 31 bits.
   localparam logic [61:0] MU_WIDE = (62'd1 << 60) / 62'd1000000007;
   localparam logic [30:0] BARRETT_MU = MU_WIDE[30:0];

   // Sum of two residues, reduced modulo the prime.
   function automatic residue_type mod_add(residue_type a, residue_type b);
      logic [RES_W:0] sum;
      logic [RES_W:0] diff;
      sum = {1'b0, a} + {1'b0, b};
      diff = sum - {1'b0, PRIME};
      if (sum >= {1'b0, PRIME}) begin
         return diff[RES_W-1:0];
      end
      return sum[RES_W-1:0];
   endfunction

endpackage
`default_nettype wire

// File: rtl/fibonacci_mod_prime_matrix_power.sv
// Top level: sequencer that raises the Fibonacci matrix to a power modulo the prime.
//
// A transaction starts when start is high while busy is low; req_index_n is taken then.
// The block squares a 2x2 accumulator once per index bit, from the top bit down, and
// multiplies by the Fibonacci matrix where the bit is set. The eight products of each
// squaring go through one shared four-stage modular multiplier, one issued per cycle.
// The result strobe rsp_valid comes after the last index bit is done and
// lasts one cycle; the receiver cannot stall it, so it must take rsp_fib_value then.
// busy stays high from acceptance until the strobe cycle.
`default_nettype none
`include "fibonacci_mod_prime_matrix_power_defines.svh"
module fibonacci_mod_prime_matrix_power #(
   parameter int INDEX_WIDTH = fmp_pkg::DEFAULT_INDEX_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [INDEX_WIDTH-1:0] req_index_n,
   output logic                        rsp_valid,
   output fmp_pkg::residue_type        rsp_fib_value
);
   import fmp_pkg::*;

   localparam int CNT_W = $clog2(INDEX_WIDTH + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SQUARE = 2'd1;
   localparam logic [1:0] ST_BASE   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [INDEX_WIDTH-1:0] n_ff, n_in;
   logic [CNT_W-1:0] bits_ff, bits_in;
   logic [3:0] iss_ff, iss_in;
   logic [2:0] col_ff, col_in;
   logic rsp_valid_ff, rsp_valid_in;
   residue_type rsp_value_ff, rsp_value_in;
   residue_type a00_ff, a01_ff, a10_ff, a11_ff;
   residue_type a00_in, a01_in, a10_in, a11_in;
   residue_type n00_ff, n01_ff, n10_ff, first_ff;
   residue_type n00_in, n01_in, n10_in, first_in;

   logic mul_in_valid;
   residue_type mul_a, mul_b;
   logic mul_out_valid;
   residue_type mul_out;
   residue_type pair_sum;
   logic advance;

   fmp_mod_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_in_valid),
      .in_a      (mul_a),
      .in_b      (mul_b),
      .out_valid (mul_out_valid),
      .out_value (mul_out)
   );

   always_comb begin
      case (iss_ff[2:0])
         3'd0: begin mul_a = a00_ff; mul_b = a00_ff; end
         3'd1: begin mul_a = a01_ff; mul_b = a10_ff; end
         3'd2: begin mul_a = a00_ff; mul_b = a01_ff; end
         3'd3: begin mul_a = a01_ff; mul_b = a11_ff; end
         3'd4: begin mul_a = a10_ff; mul_b = a00_ff; end
         3'd5: begin mul_a = a11_ff; mul_b = a10_ff; end
         3'd6: begin mul_a = a10_ff; mul_b = a01_ff; end
         default: begin mul_a = a11_ff; mul_b = a11_ff; end
      endcase
   end

   assign mul_in_valid = (state_ff == ST_SQUARE) && !iss_ff[3];
   assign pair_sum = mod_add(first_ff, mul_out);

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      bits_in = bits_ff;
      iss_in = iss_ff;
      col_in = col_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      a00_in = a00_ff;
      a01_in = a01_ff;
      a10_in = a10_ff;
      a11_in = a11_ff;
      n00_in = n00_ff;
      n01_in = n01_ff;
      n10_in = n10_ff;
      first_in = first_ff;
      advance = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SQUARE;
               n_in = req_index_n;
               bits_in = CNT_W'(INDEX_WIDTH);
               iss_in = '0;
               col_in = '0;
               a00_in = RES_W'(1);
               a01_in = '0;
               a10_in = '0;
               a11_in = RES_W'(1);
            end
         end
         ST_SQUARE: begin
            if (mul_in_valid) begin
               iss_in = iss_ff + 4'd1;
            end
            if (mul_out_valid) begin
               col_in = col_ff + 3'd1;
               if (!col_ff[0]) begin
                  first_in = mul_out;
               end else begin
                  case (col_ff[2:1])
                     2'd0: n00_in = pair_sum;
                     2'd1: n01_in = pair_sum;
                     2'd2: n10_in = pair_sum;
                     default: begin
                        a00_in = n00_ff;
                        a01_in = n01_ff;
                        a10_in = n10_ff;
                        a11_in = pair_sum;
                        if (n_ff[INDEX_WIDTH-1]) begin
                           state_in = ST_BASE;
                        end else begin
                           advance = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         ST_BASE: begin
            a00_in = a01_ff;
            a01_in = mod_add(a00_ff, a01_ff);
            a10_in = a11_ff;
            a11_in = mod_add(a10_ff, a11_ff);
            advance = 1'b1;
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = mod_add(a00_ff, a01_ff);
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (advance) begin
         n_in = n_ff << 1;
         bits_in = bits_ff - CNT_W'(1);
         iss_in = '0;
         col_in = '0;
         if (bits_ff == CNT_W'(1)) begin
            state_in = ST_FINISH;
         end else begin
            state_in = ST_SQUARE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bits_ff <= '0;
         iss_ff <= '0;
         col_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bits_ff <= bits_in;
         iss_ff <= iss_in;
         col_ff <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      rsp_value_ff <= rsp_value_in;
      a00_ff <= a00_in;
      a01_ff <= a01_in;
      a10_ff <= a10_in;
      a11_ff <= a11_in;
      n00_ff <= n00_in;
      n01_ff <= n01_in;
      n10_ff <= n10_in;
      first_ff <= first_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_fib_value = rsp_value_ff;

   `FMP_ASSERT_NEXT(a_start_sets_busy, clock, reset, start && !busy, busy)
   `FMP_ASSERT_SAME(a_rsp_after_finish, clock, reset, rsp_valid, $past(state_ff) == ST_FINISH)
   `FMP_ASSERT_SAME(a_rsp_reduced, clock, reset, rsp_valid, rsp_fib_value < PRIME)
   `FMP_ASSERT_SAME(a_products_in_square, clock, reset, mul_out_valid, state_ff == ST_SQUARE)

endmodule
`default_nettype wire

// File: rtl/fmp_mod_mul.sv
// Pipelined modular multiplier with Barrett reduction.
`default_nettype none
module fmp_mod_mul (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire fmp_pkg::residue_type in_a,
   input  wire fmp_pkg::residue_type in_b,
   output logic                     out_valid,
   output fmp_pkg::residue_type     out_value
);
   import fmp_pkg::*;

   logic [3:0]  valid_ff;
   logic [59:0] prod_ff;
   logic [61:0] est_ff;
   logic [31:0] lo2_ff;
   logic [31:0] lo3_ff;
   logic [31:0] qp_ff;
   residue_type result_ff;

   logic [61:0] est_in;
   logic [59:0] qp_full;
   logic [31:0] rem;
   logic [31:0] rem_red;
   residue_type result_in;

   always_comb begin
      est_in = {31'd0, prod_ff[59:29]} * {31'd0, BARRETT_MU};
      qp_full = {30'd0, est_ff[60:31]} * {30'd0, PRIME};
      rem = lo3_ff - qp_ff;
      if (rem >= PRIME_TWICE) begin
         rem_red = rem - PRIME_TWICE;
      end else if (rem >= {2'd0, PRIME}) begin
         rem_red = rem - {2'd0, PRIME};
      end else begin
         rem_red = rem;
      end
      result_in = rem_red[RES_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= {30'd0, in_a} * {30'd0, in_b};
      est_ff <= est_in;
      lo2_ff <= prod_ff[31:0];
      lo3_ff <= lo2_ff;
      qp_ff <= qp_full[31:0];
      result_ff <= result_in;
   end

   assign out_valid = valid_ff[3];
   assign out_value = result_ff;

endmodule
`default_nettype wire

// File: test/fibonacci_mod_prime_matrix_power_tb.sv
// Self-checking testbench for the Fibonacci matrix power block, modulo 1000000007.
module fibonacci_mod_prime_matrix_power_tb;

   localparam int IDX_W = fmp_pkg::DEFAULT_INDEX_WIDTH;
   localparam longint unsigned FIB_PRIME = 64'd1000000007;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 900;
   localparam int RANDOM_ITEMS = 760;

   typedef struct {
      logic [IDX_W-1:0] index;
      int unsigned      gap;
   } index_item_type;

   typedef struct {
      logic [IDX_W-1:0]     index;
      fmp_pkg::residue_type value;
   } fib_entry_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [IDX_W-1:0]     req_index_n;
   logic                 rsp_valid;
   fmp_pkg::residue_type rsp_fib_value;

   index_item_type index_queue[$];
   fib_entry_type  fib_expected[$];

   logic        req_taken;
   logic        block_idle;
   bit          in_flight;
   bit          gap_armed;
   int unsigned gap_left;
   int unsigned quiet_cycles;
   int unsigned error_count;
   int unsigned indices_sent;
   int unsigned results_checked;

   fibonacci_mod_prime_matrix_power u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_index_n   (req_index_n),
      .rsp_valid     (rsp_valid),
      .rsp_fib_value (rsp_fib_value)
   );

   function automatic fmp_pkg::residue_type fib_mod_prime(logic [IDX_W-1:0] n);
      longint unsigned m00;
      longint unsigned m01;
      longint unsigned m10;
      longint unsigned m11;
      longint unsigned s00;
      longint unsigned s01;
      longint unsigned s10;
      longint unsigned s11;
      longint unsigned sum;
      m00 = 1;
      m01 = 0;
      m10 = 0;
      m11 = 1;
      for (int b = IDX_W - 1; b >= 0; b--) begin
         s00 = (m00 * m00 + m01 * m10) % FIB_PRIME;
         s01 = (m00 * m01 + m01 * m11) % FIB_PRIME;
         s10 = (m10 * m00 + m11 * m10) % FIB_PRIME;
         s11 = (m10 * m01 + m11 * m11) % FIB_PRIME;
         if (n[b]) begin
            m00 = s01;
            m01 = (s00 + s01) % FIB_PRIME;
            m10 = s11;
            m11 = (s10 + s11) % FIB_PRIME;
         end else begin
            m00 = s00;
            m01 = s01;
            m10 = s10;
            m11 = s11;
         end
      end
      sum = (m00 + m01) % FIB_PRIME;
      return sum[fmp_pkg::RES_W-1:0];
   endfunction

   task automatic push_index(logic [IDX_W-1:0] index, int unsigned gap);
      index_item_type item;
      item.index = index;
      item.gap = gap;
      index_queue.push_back(item);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Request driver: presents queued indices on start after each drawn idle gap.
   always @(negedge clock) begin : request_driver
      index_item_type item;
      if (reset) begin
         start <= 1'b0;
         req_index_n <= '0;
         in_flight = 1'b0;
         gap_armed = 1'b0;
         gap_left = 0;
      end else begin
         if (req_taken) begin
            in_flight = 1'b0;
            gap_armed = 1'b0;
         end
         if (!in_flight) begin
            if (!gap_armed && index_queue.size() != 0) begin
               gap_left = index_queue[0].gap;
               gap_armed = 1'b1;
            end
            if (gap_armed && gap_left == 0) begin
               item = index_queue.pop_front();
               start <= 1'b1;
               req_index_n <= item.index;
               in_flight = 1'b1;
            end else begin
               start <= 1'b0;
               if (gap_armed && block_idle) begin
                  gap_left--;
               end
            end
         end
      end
   end

   // Monitor: records accepted requests, checks result strobes and runs the watchdog.
   always @(posedge clock) begin : result_monitor
      fib_entry_type entry;
      if (reset) begin
         req_taken <= 1'b0;
         block_idle <= 1'b0;
         quiet_cycles = 0;
         error_count = 0;
         indices_sent = 0;
         results_checked = 0;
      end else begin
         req_taken <= start && !busy;
         block_idle <= !busy;
         if (start && !busy) begin
            entry.index = req_index_n;
            entry.value = fib_mod_prime(req_index_n);
            fib_expected.push_back(entry);
            indices_sent++;
         end
         if (rsp_valid) begin
            if (fib_expected.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("ERROR: result %0d with no request outstanding", rsp_fib_value);
               end
            end else begin
               entry = fib_expected.pop_front();
               results_checked++;
               if (rsp_fib_value !== entry.value) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("ERROR: index %0d expected %0d got %0d",
                              entry.index, entry.value, rsp_fib_value);
                  end
               end
            end
         end
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("fibonacci_mod_prime_matrix_power verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [IDX_W-1:0] value;
      bit               burst;
      reset = 1'b1;

      push_index(64'd0, $urandom_range(0, 7));
      push_index(64'd1, $urandom_range(0, 7));
      push_index(64'd2, $urandom_range(0, 7));
      push_index(64'd3, 0);
      push_index(64'd10, 0);
      push_index(64'd44, $urandom_range(0, 7));
      push_index(64'd89, $urandom_range(0, 7));
      push_index({IDX_W{1'b1}}, $urandom_range(0, 7));
      push_index(64'h8000_0000_0000_0000, 0);
      push_index(64'h8000_0000_0000_0001, $urandom_range(0, 7));
      push_index(64'h5555_5555_5555_5555, $urandom_range(0, 7));
      push_index(64'hAAAA_AAAA_AAAA_AAAA, 0);
      push_index(64'h0000_0000_FFFF_FFFF, $urandom_range(0, 7));
      push_index(64'hFFFF_FFFF_0000_0000, $urandom_range(0, 7));
      push_index(64'hFFFF_FFFF_FFFF_FFFE, $urandom_range(0, 7));
      push_index(64'd1000000006, $urandom_range(0, 7));
      push_index(64'd1000000007, 0);
      push_index(64'd2000000015, $urandom_range(0, 7));
      push_index(64'd2000000016, $urandom_range(0, 7));
      push_index(64'd2000000017, $urandom_range(0, 7));

      burst = 1'b0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) begin
            burst = ($urandom_range(0, 3) == 0);
         end
         case ($urandom_range(0, 3))
            0: value = {$urandom, $urandom};
            1: value = 64'($urandom_range(0, 1000));
            2: value = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: value = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
         endcase
         push_index(value, burst ? 0 : $urandom_range(0, 7));
      end

      repeat (5) @(negedge clock);
      reset = 1'b0;

      while (index_queue.size() != 0 || in_flight || fib_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results for %0d indices: directed extremes and Pisano-period",
               results_checked, indices_sent);
      $display("neighbors, then random full-width, small, sparse and dense indices.");
      if (error_count == 0) begin
         $display("fibonacci_mod_prime_matrix_power verification clean");
      end else begin
         $display("%0d mismatches in total", error_count);
         $display("fibonacci_mod_prime_matrix_power verification failed");
      end
      $finish;
   end

endmodule
